### hdl/kwrm_pkg.sv
// ----------------------------------------------------------------------------
// kwrm_pkg
// Shared types, constants and the sort key and run count functions for the k-way record merge.
// ----------------------------------------------------------------------------
package kwrm_pkg;

   // number of runs the head store holds
   localparam int unsigned MAX_RUNS = 8;
   localparam int unsigned RUN_W    = $clog2(MAX_RUNS);
   localparam int unsigned CNT_W    = RUN_W + 1;

   // field widths
   localparam int unsigned KEY_W   = 64;
   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned ADDR_W  = 3;

   // register map, word index
   localparam logic [ADDR_W-3:0] CSR_RUNS_IN_USE = 1'b0;

   // register reset value
   localparam logic [CNT_W-1:0] RUNS_RESET = CNT_W'(MAX_RUNS);

   // item commands
   typedef enum logic {
      CMD_RECORD  = 1'b0,
      CMD_RUN_END = 1'b1
   } cmd_type;

   // per run status
   typedef enum logic [1:0] {
      RS_WAIT = 2'd0,
      RS_HEAD = 2'd1,
      RS_END  = 2'd2
   } run_status_type;

   // input transaction
   typedef struct packed {
      logic               cmd;
      logic [2:0]         run_index;
      logic [KEY_W-1:0]   record_key;
      logic [VALUE_W-1:0] record_value;
   } req_type;

   // result transaction
   typedef struct packed {
      logic               out_valid;
      logic [KEY_W-1:0]   out_key;
      logic [VALUE_W-1:0] out_value;
      logic [2:0]         refill_run;
      logic               merge_done;
      logic               protocol_error;
   } rsp_type;

   // record key to sort key: cell stays on top, then tag, gene, umi
   function automatic logic [KEY_W-1:0] sort_key(input logic [KEY_W-1:0] k);
      sort_key = {k[63:44], k[4:0], k[19:5], k[43:20]};
   endfunction

   // register value to effective run count: zero acts as one, clamp at max
   function automatic logic [CNT_W-1:0] active_runs(input logic [3:0] r);
      logic [CNT_W-1:0] res;
      if (r == 4'd0) begin
         res = CNT_W'(1);
      end else if (32'(r) > MAX_RUNS) begin
         res = CNT_W'(MAX_RUNS);
      end else begin
         res = CNT_W'(r);
      end
      active_runs = res;
   endfunction

endpackage

### hdl/kway_record_merge.sv
// ----------------------------------------------------------------------------
// kway_record_merge
// Merges up to eight sorted record runs, one head record per run, emitting the
// smallest head by sort key and naming its run for refill.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake             payload
//   req       in         req_valid/req_stall   req_data (req_type)
//   rsp       out        rsp_valid/rsp_stall   rsp_data (rsp_type)
//   csr       in/out     psel/penable/pready   paddr, pwdata, prdata
//
// an item that completes the head set takes accept, fill check, a compare of
// each run in use on the shared key comparator, and result load; one that
// leaves runs unfilled ends at the fill check, a rejected one goes to result load.
// the single comparator walks the heads one per cycle, that sets the rate.
// reset is synchronous active high; all runs await their first record.
// a stalled result holds in the output register; the block keeps accepting
// until it needs to load a new result.
module kway_record_merge
   import kwrm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   // configuration port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [CSR_W-1:0]   pwdata,
   output logic [CSR_W-1:0]   prdata,
   output logic               pready
);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_CHECK  = 4'b0010,
      S_SCAN   = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [3:0]           runs_ff, runs_in;
   run_status_type       status_ff [MAX_RUNS];
   run_status_type       status_in [MAX_RUNS];
   logic [KEY_W-1:0]     head_key_ff [MAX_RUNS];
   logic [VALUE_W-1:0]   head_value_ff [MAX_RUNS];
   logic [RUN_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 err_ff, err_in;
   logic                 best_valid_ff, best_valid_in;
   logic [KEY_W-1:0]     best_sk_ff, best_sk_in;
   logic [KEY_W-1:0]     best_key_ff, best_key_in;
   logic [VALUE_W-1:0]   best_value_ff, best_value_in;
   logic [RUN_W-1:0]     best_run_ff, best_run_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 cfg_write;
   logic [CNT_W-1:0]     n_eff;
   logic                 req_accept;
   logic [RUN_W-1:0]     req_run;
   logic                 req_err;
   logic                 all_filled;
   logic                 out_free;
   logic [KEY_W-1:0]     cur_sk;
   logic                 cur_eligible;
   logic                 cur_wins;
   logic                 scan_last;

   // configuration port
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready &&
                      (paddr[ADDR_W-1:2] == CSR_RUNS_IN_USE);
   assign prdata    = (paddr[ADDR_W-1:2] == CSR_RUNS_IN_USE) ?
                      {{(CSR_W-4){1'b0}}, runs_ff} : '0;
   assign runs_in   = cfg_write ? pwdata[3:0] : runs_ff;
   assign n_eff     = active_runs(runs_ff);

   // input side
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_run    = req_data.run_index[RUN_W-1:0];
   assign req_err    = ({1'b0, req_data.run_index} >= n_eff) ||
                       (status_ff[req_run] != RS_WAIT);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // every run in use has a head or has ended
   always_comb begin
      all_filled = 1'b1;
      for (int i = 0; i < MAX_RUNS; i++) begin
         if ((CNT_W'(i) < n_eff) && (status_ff[i] == RS_WAIT)) begin
            all_filled = 1'b0;
         end
      end
   end

   // shared comparator, one head per cycle
   assign cur_sk       = sort_key(head_key_ff[scan_idx_ff]);
   assign cur_eligible = (status_ff[scan_idx_ff] == RS_HEAD);
   assign cur_wins     = cur_eligible && (!best_valid_ff || (cur_sk < best_sk_ff));
   assign scan_last    = ({1'b0, scan_idx_ff} == (n_eff - CNT_W'(1)));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      err_in        = err_ff;
      best_valid_in = best_valid_ff;
      best_sk_in    = best_sk_ff;
      best_key_in   = best_key_ff;
      best_value_in = best_value_ff;
      best_run_in   = best_run_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      for (int i = 0; i < MAX_RUNS; i++) begin
         status_in[i] = status_ff[i];
      end

      // result register drains
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               err_in = req_err;
               if (req_err) begin
                  state_in = S_RESULT;
               end else begin
                  status_in[req_run] = (req_data.cmd == CMD_RECORD) ? RS_HEAD : RS_END;
                  state_in           = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            scan_idx_in   = '0;
            best_valid_in = 1'b0;
            state_in      = all_filled ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            if (cur_wins) begin
               best_valid_in = 1'b1;
               best_sk_in    = cur_sk;
               best_key_in   = head_key_ff[scan_idx_ff];
               best_value_in = head_value_ff[scan_idx_ff];
               best_run_in   = scan_idx_ff;
            end
            scan_idx_in = scan_idx_ff + RUN_W'(1);
            if (scan_last) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (err_ff) begin
                  rsp_data_in.protocol_error = 1'b1;
               end else if (best_valid_ff) begin
                  rsp_data_in.out_valid  = 1'b1;
                  rsp_data_in.out_key    = best_key_ff;
                  rsp_data_in.out_value  = best_value_ff;
                  rsp_data_in.refill_run = 3'(best_run_ff);
                  status_in[best_run_ff] = RS_WAIT;
               end else begin
                  rsp_data_in.merge_done = 1'b1;
                  for (int i = 0; i < MAX_RUNS; i++) begin
                     status_in[i] = RS_WAIT;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a register write aborts the merge
      if (cfg_write) begin
         state_in = S_IDLE;
         for (int i = 0; i < MAX_RUNS; i++) begin
            status_in[i] = RS_WAIT;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         runs_ff      <= RUNS_RESET[3:0];
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_RUNS; i++) begin
            status_ff[i] <= RS_WAIT;
         end
      end else begin
         state_ff     <= state_in;
         runs_ff      <= runs_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < MAX_RUNS; i++) begin
            status_ff[i] <= status_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      err_ff        <= err_in;
      best_valid_ff <= best_valid_in;
      best_sk_ff    <= best_sk_in;
      best_key_ff   <= best_key_in;
      best_value_ff <= best_value_in;
      best_run_ff   <= best_run_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // head store, written only by an accepted record
   always_ff @(posedge clock) begin
      if (req_accept && !req_err && (req_data.cmd == CMD_RECORD)) begin
         head_key_ff[req_run]   <= req_data.record_key;
         head_value_ff[req_run] <= req_data.record_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result carries exactly one kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_data.out_valid, rsp_data.merge_done,
                                rsp_data.protocol_error}) == 1)
      else $error("result carries more than one kind");

   // the chosen winner still holds a head when the result is loaded
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT) && !err_ff && best_valid_ff |->
         status_ff[best_run_ff] == RS_HEAD)
      else $error("winner run holds no head");

   // a done result leaves the first and last runs awaiting their first record
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESULT) && out_free && !err_ff && !best_valid_ff |=>
         (status_ff[0] == RS_WAIT) && (status_ff[MAX_RUNS-1] == RS_WAIT))
      else $error("run status not cleared after done");

   // an accepted item leaves the idle state unless a register write aborts it
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !cfg_write |=> state_ff != S_IDLE)
      else $error("accepted transaction not processed");

endmodule
